// File: hw/rtl/csb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types, register map, reset values and the pixel blend function for the
// clipped sprite blitter.
// ----------------------------------------------------------------------------
package csb_pkg;

  localparam int MAX_DIM_DEF = 4096;

  // APB address width: seven 32-bit registers at byte offsets 0..24
  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_SURF_W = 3'd0;
  localparam logic [2:0] REG_SURF_H = 3'd1;
  localparam logic [2:0] REG_CLIP_L = 3'd2;
  localparam logic [2:0] REG_CLIP_T = 3'd3;
  localparam logic [2:0] REG_CLIP_R = 3'd4;
  localparam logic [2:0] REG_CLIP_B = 3'd5;
  localparam logic [2:0] REG_BRIGHT = 3'd6;

  localparam logic [12:0] SURF_W_RST = 13'd640;
  localparam logic [12:0] SURF_H_RST = 13'd480;
  localparam logic [15:0] CLIP_L_RST = 16'hFFFF;
  localparam logic [15:0] CLIP_T_RST = 16'd0;
  localparam logic [15:0] CLIP_R_RST = 16'd640;
  localparam logic [15:0] CLIP_B_RST = 16'd480;
  localparam logic [7:0]  BRIGHT_RST = 8'd48;

  localparam logic [1:0] MODE_COPY     = 2'd0;
  localparam logic [1:0] MODE_HALVE    = 2'd1;
  localparam logic [1:0] MODE_BRIGHTEN = 2'd2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [12:0]        surf_w;
    logic [12:0]        surf_h;
    logic signed [15:0] clip_l;
    logic signed [15:0] clip_t;
    logic signed [15:0] clip_r;
    logic signed [15:0] clip_b;
    logic [7:0]         bright;
  } csb_cfg_t;

  // New pixel value for a written pixel; unused mode copies the source.
  function automatic logic [31:0] csb_blend(input logic [1:0]  mode,
                                            input logic [31:0] src,
                                            input logic [31:0] dst,
                                            input logic [7:0]  amt);
    logic [31:0] res;
    logic [8:0]  sum;
    res = src;
    sum = '0;
    case (mode)
      MODE_HALVE: begin
        res = {ALPHA_OPAQUE, 1'b0, dst[23:17], 1'b0, dst[15:9], 1'b0, dst[7:1]};
      end
      MODE_BRIGHTEN: begin
        res[31:24] = ALPHA_OPAQUE;
        for (int i = 0; i < 3; i++) begin
          sum = {1'b0, dst[8*i +: 8]} + {1'b0, amt};
          res[8*i +: 8] = sum[8] ? 8'hFF : sum[7:0];
        end
      end
      default: begin
        res = src;
      end
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/csb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_regs
// APB register file holding surface size, clip box and brighten amount.
// ----------------------------------------------------------------------------
module csb_regs
  import csb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output csb_cfg_t          cfg
);

  csb_cfg_t    cfg_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.surf_w <= SURF_W_RST;
      cfg_r.surf_h <= SURF_H_RST;
      cfg_r.clip_l <= CLIP_L_RST;
      cfg_r.clip_t <= CLIP_T_RST;
      cfg_r.clip_r <= CLIP_R_RST;
      cfg_r.clip_b <= CLIP_B_RST;
      cfg_r.bright <= BRIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SURF_W: cfg_r.surf_w <= pwdata[12:0];
        REG_SURF_H: cfg_r.surf_h <= pwdata[12:0];
        REG_CLIP_L: cfg_r.clip_l <= pwdata[15:0];
        REG_CLIP_T: cfg_r.clip_t <= pwdata[15:0];
        REG_CLIP_R: cfg_r.clip_r <= pwdata[15:0];
        REG_CLIP_B: cfg_r.clip_b <= pwdata[15:0];
        REG_BRIGHT: cfg_r.bright <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SURF_W: prdata = {19'd0, cfg_r.surf_w};
      REG_SURF_H: prdata = {19'd0, cfg_r.surf_h};
      REG_CLIP_L: prdata = {{16{cfg_r.clip_l[15]}}, cfg_r.clip_l};
      REG_CLIP_T: prdata = {{16{cfg_r.clip_t[15]}}, cfg_r.clip_t};
      REG_CLIP_R: prdata = {{16{cfg_r.clip_r[15]}}, cfg_r.clip_r};
      REG_CLIP_B: prdata = {{16{cfg_r.clip_b[15]}}, cfg_r.clip_b};
      REG_BRIGHT: prdata = {24'd0, cfg_r.bright};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// File: hw/rtl/clipped_sprite_blit_modes_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_sprite_blit_modes_top
// Sprite blitter: places raster-order pixels, clips them and blends.
// Path: input transfer, stage 1 register, result register, out_valid.
// Throughput: one pixel per cycle unless out_stall holds; stage 1 computes
// position, clip and blend, the result stage forms the 13x13 address product.
// Reset (rst_n, synchronous): counters, valid flags and registers to defaults.
// ----------------------------------------------------------------------------
module clipped_sprite_blit_modes_top
  import csb_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // pixel input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_first_pixel,
  input  logic [31:0]       in_source_argb,
  input  logic [31:0]       in_dest_argb,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [12:0]       in_sprite_width,
  input  logic [1:0]        in_blend_mode,
  // pixel result
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_write_enable,
  output logic [31:0]       out_pixel_out,
  output logic [23:0]       out_pixel_address
);

  localparam int CW  = $clog2(MAX_DIM);
  localparam int DXW = ((CW > 15) ? CW : 15) + 2;
  localparam int DYW = 18;
  localparam int SWW = ((CW + 1) > 13) ? (CW + 1) : 13;
  localparam logic [SWW-1:0] MAX_W = SWW'(MAX_DIM);

  csb_cfg_t cfg;

  csb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake
  logic in_acc, out_free, s1_move;
  logic s1_v_r, out_v_r;

  assign out_free = ~out_v_r | ~out_stall;
  assign s1_move  = s1_v_r & out_free;
  assign in_stall = s1_v_r & ~out_free;
  assign in_acc   = in_valid & ~in_stall;

  // sprite position counters
  logic [CW-1:0]  col_r, col_nxt, base_col;
  logic [15:0]    row_r, row_nxt, base_row;
  logic [CW:0]    col_inc;
  logic [SWW-1:0] sw_ext, sw_eff;

  assign base_col = in_first_pixel ? '0 : col_r;
  assign base_row = in_first_pixel ? '0 : row_r;
  assign sw_ext   = SWW'(in_sprite_width);
  assign col_inc  = {1'b0, base_col} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    if (sw_ext == '0) begin
      sw_eff = SWW'(1);
    end else if (sw_ext > MAX_W) begin
      sw_eff = MAX_W;
    end else begin
      sw_eff = sw_ext;
    end
    if (SWW'(col_inc) >= sw_eff) begin
      col_nxt = '0;
      row_nxt = base_row + 16'd1;
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = base_row;
    end
  end

  // screen position and clip test
  logic signed [DXW-1:0] dx, sw_s, cl_s, cr_s;
  logic signed [DYW-1:0] dy, sh_s, ct_s, cb_s;
  logic                  we_nxt;
  logic [31:0]           pix_nxt;

  assign dx   = {{(DXW-16){in_origin_x[15]}}, in_origin_x} + {{(DXW-CW){1'b0}}, base_col};
  assign dy   = {{(DYW-16){in_origin_y[15]}}, in_origin_y} + {{(DYW-16){1'b0}}, base_row};
  assign sw_s = {{(DXW-13){1'b0}}, cfg.surf_w};
  assign sh_s = {{(DYW-13){1'b0}}, cfg.surf_h};
  assign cl_s = {{(DXW-16){cfg.clip_l[15]}}, cfg.clip_l};
  assign cr_s = {{(DXW-16){cfg.clip_r[15]}}, cfg.clip_r};
  assign ct_s = {{(DYW-16){cfg.clip_t[15]}}, cfg.clip_t};
  assign cb_s = {{(DYW-16){cfg.clip_b[15]}}, cfg.clip_b};

  assign we_nxt = (in_source_argb[31:24] != 8'd0)
               && (dx >= 0) && (dx < sw_s) && (dy >= 0) && (dy < sh_s)
               && (dx > cl_s) && (dx < cr_s) && (dy >= ct_s) && (dy < cb_s);

  assign pix_nxt = we_nxt ? csb_blend(in_blend_mode, in_source_argb, in_dest_argb, cfg.bright)
                          : 32'd0;

  // stage 1 registers
  logic        s1_we_r;
  logic [31:0] s1_pix_r;
  logic [12:0] s1_dx_r, s1_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_we_r  <= we_nxt;
      s1_pix_r <= pix_nxt;
      // when writing, both coordinates lie on the surface and fit 13 bits
      s1_dx_r  <= dx[12:0];
      s1_dy_r  <= dy[12:0];
    end
  end

  // address and result register
  logic [25:0] addr_full;
  logic        out_we_r;
  logic [31:0] out_pix_r;
  logic [23:0] out_addr_r;

  assign addr_full = ({13'd0, s1_dy_r} * {13'd0, cfg.surf_w}) + {13'd0, s1_dx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_we_r   <= s1_we_r;
      out_pix_r  <= s1_pix_r;
      out_addr_r <= s1_we_r ? addr_full[23:0] : 24'd0;
    end
  end

  assign out_valid         = out_v_r;
  assign out_write_enable  = out_we_r;
  assign out_pixel_out     = out_pix_r;
  assign out_pixel_address = out_addr_r;

  // checks
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_pixel_out == 32'd0 && out_pixel_address == 24'd0)
    else $error("non-written result carries data");

  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_first_pixel |=>
      (col_r == CW'(1) && row_r == 16'd0) || (col_r == '0 && row_r == 16'd1))
    else $error("first pixel did not restart counters");

  a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && out_stall |=> s1_v_r && $stable(s1_pix_r))
    else $error("stage 1 item lost while output stalled");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && out_v_r)
    else $error("input stalled with free pipeline room");

endmodule
